[rtl/core/md5_pkg.sv]
// ----------------------------------------------------------------------------
// md5_pkg
// Shared types, initial chaining values and round tables of the MD5 engine.
// ----------------------------------------------------------------------------
package md5_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PACK,
        ST_ZERO,
        ST_LOAD,
        ST_ROUND,
        ST_ADD,
        ST_OUT
    } t_state;

    localparam logic [31:0] IV_A = 32'h67452301;
    localparam logic [31:0] IV_B = 32'hefcdab89;
    localparam logic [31:0] IV_C = 32'h98badcfe;
    localparam logic [31:0] IV_D = 32'h10325476;

    localparam logic [31:0] PAD_BYTE = 32'h0000_0080;

    // Additive constant of each round.
    function automatic logic [31:0] md5_k(input logic [5:0] t);
        logic [31:0] k;
        case (t)
            6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
            6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
            6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
            6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
            6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
            6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
            6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
            6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
            6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
            6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
            6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
            6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
            6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
            6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
            6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
            6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
            6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
            6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
            6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
            6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
            6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
            6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
            6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
            6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
            6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
            6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
            6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
            6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
            6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
            6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
            6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
            6'd62: k = 32'h2ad7d2bb;  6'd63: k = 32'heb86d391;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

    // Left rotation of each round, chosen by phase and the low two bits.
    function automatic logic [4:0] md5_s(input logic [5:0] t);
        logic [4:0] s;
        case ({t[5:4], t[1:0]})
            4'd0:  s = 5'd7;   4'd1:  s = 5'd12;  4'd2:  s = 5'd17;  4'd3:  s = 5'd22;
            4'd4:  s = 5'd5;   4'd5:  s = 5'd9;   4'd6:  s = 5'd14;  4'd7:  s = 5'd20;
            4'd8:  s = 5'd4;   4'd9:  s = 5'd11;  4'd10: s = 5'd16;  4'd11: s = 5'd23;
            4'd12: s = 5'd6;   4'd13: s = 5'd10;  4'd14: s = 5'd15;  4'd15: s = 5'd21;
            default: s = 5'd0;
        endcase
        return s;
    endfunction

    // Message word taken by each round.
    function automatic logic [3:0] md5_g(input logic [5:0] t);
        logic [3:0] g;
        case (t[5:4])
            2'd0:    g = t[3:0];
            2'd1:    g = 4'(5 * t[3:0] + 1);
            2'd2:    g = 4'(3 * t[3:0] + 5);
            default: g = 4'(7 * t[3:0]);
        endcase
        return g;
    endfunction

endpackage

[rtl/core/md5_round.sv]
// ----------------------------------------------------------------------------
// md5_round
// One MD5 step: round function, four-operand sum and left rotation.
// ----------------------------------------------------------------------------
module md5_round (
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    input  logic [31:0] i_c,
    input  logic [31:0] i_d,
    input  logic [31:0] i_m,
    input  logic [5:0]  i_round,
    output logic [31:0] o_b
);
    import md5_pkg::*;

    logic [31:0] w_f;
    logic [31:0] w_sum;
    logic [63:0] w_dbl;
    logic [4:0]  w_rot;

    always_comb begin
        case (i_round[5:4])
            2'd0:    w_f = (i_b & i_c) | (~i_b & i_d);
            2'd1:    w_f = (i_d & i_b) | (~i_d & i_c);
            2'd2:    w_f = i_b ^ i_c ^ i_d;
            default: w_f = i_c ^ (i_b | ~i_d);
        endcase
    end

    assign w_sum = i_a + w_f + md5_k(i_round) + i_m;
    assign w_rot = md5_s(i_round);
    // Rotation as a shift of the doubled word; the upper half holds the result.
    assign w_dbl = {w_sum, w_sum} << w_rot;
    assign o_b   = i_b + w_dbl[63:32];

endmodule

[rtl/core/md5_hash_engine.sv]
// ----------------------------------------------------------------------------
// md5_hash_engine
// Streaming MD5 digest: packs message bytes, pads, and compresses blocks.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake          Payload
//  -------  ---------  -----------------  -----------------------------------
//  message  in         i_valid / o_stall  i_data_word, i_byte_count, i_last_word
//  digest   out        o_valid / i_stall  o_digest_word0 .. o_digest_word3
//
//  A message request is taken when the engine is idle; its bytes go straight
//  into the block buffer. Each full block stalls the input while it runs on
//  the single shared round unit (one load, 64 rounds, one chaining add and
//  one packing step that resumes any remainder). The final word adds padding
//  and one or two further blocks before the digest is registered. Reset is
//  synchronous and active low and needs no clearing pass. A stalled digest
//  holds the engine in its output state only when a second digest is ready
//  before the first one has been taken.
//
module md5_hash_engine (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_data_word,
    input  logic [2:0]  i_byte_count,
    input  logic        i_last_word,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_digest_word0,
    output logic [31:0] o_digest_word1,
    output logic [31:0] o_digest_word2,
    output logic [31:0] o_digest_word3
);
    import md5_pkg::*;

    t_state r_state, n_state;

    // Block buffer and round registers.
    logic [31:0] r_buf [16];
    logic [31:0] r_a, r_b, r_c, r_d;
    logic [31:0] n_a, n_b, n_c, n_d;
    logic [31:0] r_h0, r_h1, r_h2, r_h3;
    logic [31:0] n_h0, n_h1, n_h2, n_h3;
    logic [5:0]  r_round, n_round;

    // Byte position within the current block and total message length.
    logic [5:0]  r_fill, n_fill;
    logic [60:0] r_msg, n_msg;

    // Bytes of a word still to be packed, carried over a block compression.
    logic [31:0] r_word, n_word;
    logic [2:0]  r_cnt, n_cnt;
    logic        r_last, n_last;
    logic        r_pad, n_pad;
    logic        r_final, n_final;

    logic        r_out_valid, n_out_valid;
    logic [31:0] r_dig0, r_dig1, r_dig2, r_dig3;
    logic [31:0] n_dig0, n_dig1, n_dig2, n_dig3;

    // Packing path: source is the incoming request when idle, else the
    // carried-over remainder or the padding marker.
    logic        w_accept;
    logic        w_pack;
    logic [2:0]  w_in_cnt;
    logic [31:0] pk_word;
    logic [2:0]  pk_cnt;
    logic        pk_last;
    logic        pk_pad;
    logic [6:0]  pk_space;
    logic [2:0]  pk_k;
    logic [6:0]  pk_sum;
    logic [63:0] w_bit_len;
    logic [31:0] w_round_b;

    assign o_stall  = (r_state != ST_IDLE);
    assign w_accept = i_valid && (r_state == ST_IDLE);
    assign w_pack   = w_accept || (r_state == ST_PACK);

    // Counts above four are treated as a full word.
    assign w_in_cnt = (i_byte_count > 3'd4) ? 3'd4 : i_byte_count;

    assign pk_word  = (r_state == ST_IDLE) ? i_data_word : r_word;
    assign pk_cnt   = (r_state == ST_IDLE) ? w_in_cnt    : r_cnt;
    assign pk_last  = (r_state == ST_IDLE) ? i_last_word : r_last;
    assign pk_pad   = (r_state == ST_IDLE) ? 1'b0        : r_pad;

    // Only as many bytes as the block still has room for go in now; the
    // space is below four whenever it limits the count.
    assign pk_space = 7'd64 - {1'b0, r_fill};
    assign pk_k     = ({4'd0, pk_cnt} > pk_space) ? pk_space[2:0] : pk_cnt;
    assign pk_sum   = {1'b0, r_fill} + {4'd0, pk_k};

    assign w_bit_len = {r_msg, 3'b000};

    md5_round u_round (
        .i_a     (r_a),
        .i_b     (r_b),
        .i_c     (r_c),
        .i_d     (r_d),
        .i_m     (r_buf[md5_g(r_round)]),
        .i_round (r_round),
        .o_b     (w_round_b)
    );

    // Block buffer writes: packed bytes, zero fill and the length words.
    always_ff @(posedge i_clk) begin
        if (w_pack) begin
            for (int j = 0; j < 4; j++) begin
                if (3'(j) < pk_k) begin
                    r_buf[4'((r_fill + 6'(j)) >> 2)][8 * ((r_fill + 6'(j)) & 6'd3) +: 8]
                        <= pk_word[8 * j +: 8];
                end
            end
        end else if (r_state == ST_ZERO) begin
            if (r_fill == 6'd56) begin
                r_buf[14] <= w_bit_len[31:0];
                r_buf[15] <= w_bit_len[63:32];
            end else begin
                for (int j = 0; j < 4; j++) begin
                    if (2'(j) >= r_fill[1:0]) begin
                        r_buf[r_fill[5:2]][8 * j +: 8] <= 8'h00;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_round     <= 6'd0;
            r_fill      <= 6'd0;
            r_msg       <= 61'd0;
            r_cnt       <= 3'd0;
            r_last      <= 1'b0;
            r_pad       <= 1'b0;
            r_final     <= 1'b0;
            r_out_valid <= 1'b0;
            r_h0        <= IV_A;
            r_h1        <= IV_B;
            r_h2        <= IV_C;
            r_h3        <= IV_D;
        end else begin
            r_state     <= n_state;
            r_round     <= n_round;
            r_fill      <= n_fill;
            r_msg       <= n_msg;
            r_cnt       <= n_cnt;
            r_last      <= n_last;
            r_pad       <= n_pad;
            r_final     <= n_final;
            r_out_valid <= n_out_valid;
            r_h0        <= n_h0;
            r_h1        <= n_h1;
            r_h2        <= n_h2;
            r_h3        <= n_h3;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
        r_a    <= n_a;
        r_b    <= n_b;
        r_c    <= n_c;
        r_d    <= n_d;
        r_dig0 <= n_dig0;
        r_dig1 <= n_dig1;
        r_dig2 <= n_dig2;
        r_dig3 <= n_dig3;
    end

    always_comb begin
        n_state     = r_state;
        n_round     = r_round;
        n_fill      = r_fill;
        n_msg       = r_msg;
        n_word      = r_word;
        n_cnt       = r_cnt;
        n_last      = r_last;
        n_pad       = r_pad;
        n_final     = r_final;
        n_a         = r_a;
        n_b         = r_b;
        n_c         = r_c;
        n_d         = r_d;
        n_h0        = r_h0;
        n_h1        = r_h1;
        n_h2        = r_h2;
        n_h3        = r_h3;
        n_dig0      = r_dig0;
        n_dig1      = r_dig1;
        n_dig2      = r_dig2;
        n_dig3      = r_dig3;
        n_out_valid = r_out_valid;

        if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_msg = r_msg + {58'd0, w_in_cnt};
                end
            end
            ST_ZERO: begin
                if (r_fill == 6'd56) begin
                    n_final = 1'b1;
                    n_state = ST_LOAD;
                end else begin
                    n_fill = {r_fill[5:2] + 4'd1, 2'b00};
                    if (r_fill[5:2] == 4'd15) begin
                        n_state = ST_LOAD;
                    end
                end
            end
            ST_LOAD: begin
                n_a     = r_h0;
                n_b     = r_h1;
                n_c     = r_h2;
                n_d     = r_h3;
                n_round = 6'd0;
                n_state = ST_ROUND;
            end
            ST_ROUND: begin
                n_a     = r_d;
                n_b     = w_round_b;
                n_c     = r_b;
                n_d     = r_c;
                n_round = r_round + 6'd1;
                if (r_round == 6'd63) begin
                    n_state = ST_ADD;
                end
            end
            ST_ADD: begin
                n_h0    = r_h0 + r_a;
                n_h1    = r_h1 + r_b;
                n_h2    = r_h2 + r_c;
                n_h3    = r_h3 + r_d;
                // Unless final, packing resumes any remainder or decides.
                n_state = r_final ? ST_OUT : ST_PACK;
            end
            ST_OUT: begin
                if (!r_out_valid || !i_stall) begin
                    n_dig0      = r_h0;
                    n_dig1      = r_h1;
                    n_dig2      = r_h2;
                    n_dig3      = r_h3;
                    n_out_valid = 1'b1;
                    n_h0        = IV_A;
                    n_h1        = IV_B;
                    n_h2        = IV_C;
                    n_h3        = IV_D;
                    n_msg       = 61'd0;
                    n_fill      = 6'd0;
                    n_cnt       = 3'd0;
                    n_last      = 1'b0;
                    n_pad       = 1'b0;
                    n_final     = 1'b0;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
            end
        endcase

        if (w_pack) begin
            n_fill = pk_sum[5:0];
            if (pk_sum[6]) begin
                // Block full: keep what is left of the word for afterwards.
                n_word  = pk_word >> {pk_k, 3'b000};
                n_cnt   = pk_cnt - pk_k;
                n_last  = pk_last;
                n_pad   = pk_pad;
                n_state = ST_LOAD;
            end else if (pk_last) begin
                // Message ended: the marker byte goes through the same path.
                n_word  = PAD_BYTE;
                n_cnt   = 3'd1;
                n_last  = 1'b0;
                n_pad   = 1'b1;
                n_state = ST_PACK;
            end else if (pk_pad) begin
                n_cnt   = 3'd0;
                n_state = ST_ZERO;
            end else begin
                n_cnt   = 3'd0;
                n_state = ST_IDLE;
            end
        end
    end

    assign o_valid        = r_out_valid;
    assign o_digest_word0 = r_dig0;
    assign o_digest_word1 = r_dig1;
    assign o_digest_word2 = r_dig2;
    assign o_digest_word3 = r_dig3;

endmodule

[bench/md5_hash_engine_tb.sv]
// ----------------------------------------------------------------------------
// md5_hash_engine_tb
// Self-checking bench for the streaming MD5 engine. A directed table covers
// the standard digests and the odd byte counts. Random messages follow, with
// lengths weighted towards the padding boundaries. Every digest is compared
// word by word with an in-bench MD5 model or with a typed row's digest.
// ----------------------------------------------------------------------------
module md5_hash_engine_tb;

    import md5_pkg::*;

    // Digests of the empty string and of "abc", as little-endian words.
    // They are packed as {word3, word2, word1, word0}.
    localparam logic [127:0] EMPTY_DIGEST =
        {32'h7e42f8ec, 32'h980980e9, 32'h04b2008f, 32'hd98c1dd4};
    localparam logic [127:0] ABC_DIGEST =
        {32'h727fe128, 32'h7d3f96d6, 32'hb04fd23c, 32'h98500190};

    localparam int unsigned RANDOM_REQUESTS = 1430;
    localparam int unsigned DRAIN_LIMIT     = 20000;
    localparam int unsigned SETTLE_CYCLES   = 200;
    localparam int unsigned DIRECTED_ROWS   = 19;

    // One row of the directed table. When typed is set, the digest column
    // holds the expected value and the model's value is not used.
    typedef struct packed {
        logic [31:0]  data;
        logic [2:0]   cnt;
        logic         last;
        logic         typed;
        logic [127:0] digest;
    } t_stim_row;

    t_stim_row directed_rows [DIRECTED_ROWS] = '{
        // An empty message, then an empty one whose data bits must be ignored.
        '{32'h0000_0000, 3'd0, 1'b1, 1'b1, EMPTY_DIGEST},
        '{32'hffff_ffff, 3'd0, 1'b1, 1'b1, EMPTY_DIGEST},
        // "abc" in a single short word. The unused top byte is set.
        '{32'hff63_6261, 3'd3, 1'b1, 1'b1, ABC_DIGEST},
        // All-ones and all-zeros words, then a count above four.
        '{32'hffff_ffff, 3'd4, 1'b1, 1'b0, '0},
        '{32'h0000_0000, 3'd4, 1'b1, 1'b0, '0},
        '{32'hffff_ffff, 3'd7, 1'b1, 1'b0, '0},
        // Short and oversized words in the middle of one message.
        '{32'ha5a5_a5a5, 3'd5, 1'b0, 1'b0, '0},
        '{32'h1234_5678, 3'd1, 1'b0, 1'b0, '0},
        '{32'h9abc_def0, 3'd2, 1'b0, 1'b0, '0},
        '{32'h0000_0000, 3'd0, 1'b0, 1'b0, '0},
        '{32'hdead_beef, 3'd6, 1'b0, 1'b0, '0},
        '{32'hcafe_f00d, 3'd3, 1'b1, 1'b0, '0},
        // "abc" split as "ab" and "c": the bytes must join up without a gap.
        '{32'h0000_6261, 3'd2, 1'b0, 1'b0, '0},
        '{32'h0000_0063, 3'd1, 1'b1, 1'b1, ABC_DIGEST},
        // "abc" one byte at a time, junk in the unused bytes of the first two.
        '{32'hffff_ff61, 3'd1, 1'b0, 1'b0, '0},
        '{32'hffff_ff62, 3'd1, 1'b0, 1'b0, '0},
        '{32'h0000_0063, 3'd1, 1'b1, 1'b1, ABC_DIGEST},
        // "abc" closed by a last word that carries no bytes.
        '{32'h0063_6261, 3'd3, 1'b0, 1'b0, '0},
        '{32'h5a5a_5a5a, 3'd0, 1'b1, 1'b1, ABC_DIGEST}
    };

    // Additive constants and rotation amounts of the 64 rounds.
    logic [31:0] round_add [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };
    int unsigned rot_amount [16] = '{
        7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21
    };

    // Clock, reset and the ports of the engine. Every input has a known value
    // from time zero.
    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_valid = 1'b0;
    logic         o_stall;
    logic [31:0]  i_data_word = '0;
    logic [2:0]   i_byte_count = '0;
    logic         i_last_word = 1'b0;
    logic         o_valid;
    logic         i_stall = 1'b0;
    logic [31:0]  o_digest_word0;
    logic [31:0]  o_digest_word1;
    logic [31:0]  o_digest_word2;
    logic [31:0]  o_digest_word3;

    // Typed expectation carried alongside the request that is on the bus.
    logic         req_typed = 1'b0;
    logic [127:0] req_typed_digest = '0;

    // Model state: chaining values, block buffer, fill level and byte count.
    logic [31:0]  chain_hv [4];
    logic [31:0]  block_words [16];
    logic [5:0]   block_fill;
    logic [60:0]  message_len;

    // Digests still owed by the engine, oldest first.
    logic [127:0] pending_digests [$];
    int unsigned  fail_count = 0;

    // State of the sender's bursts and of the receiver's stall pattern.
    int unsigned  burst_left = 0;
    int unsigned  stall_left = 0;
    int unsigned  stall_mode = 0;

    always #2 i_clk = ~i_clk;

    md5_hash_engine dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_data_word    (i_data_word),
        .i_byte_count   (i_byte_count),
        .i_last_word    (i_last_word),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_digest_word0 (o_digest_word0),
        .o_digest_word1 (o_digest_word1),
        .o_digest_word2 (o_digest_word2),
        .o_digest_word3 (o_digest_word3)
    );

    function automatic logic [31:0] rotate_left(input logic [31:0] x, input int unsigned n);
        return (x << n) | (x >> (32 - n));
    endfunction

    // Puts the model back into its idle state, ready for a new message.
    task automatic md5_restart();
        chain_hv[0] = IV_A;
        chain_hv[1] = IV_B;
        chain_hv[2] = IV_C;
        chain_hv[3] = IV_D;
        for (int i = 0; i < 16; i++) begin
            block_words[i] = '0;
        end
        block_fill  = '0;
        message_len = '0;
    endtask

    // Sixty-four rounds over the block buffer, folded into the chaining values.
    task automatic md5_compress();
        logic [31:0] a, b, c, d, f, tmp;
        int unsigned g, ph;
        a = chain_hv[0];
        b = chain_hv[1];
        c = chain_hv[2];
        d = chain_hv[3];
        for (int t = 0; t < 64; t++) begin
            ph = t / 16;
            case (ph)
                0: begin
                    f = (b & c) | (~b & d);
                    g = t;
                end
                1: begin
                    f = (d & b) | (~d & c);
                    g = (5 * t + 1) % 16;
                end
                2: begin
                    f = b ^ c ^ d;
                    g = (3 * t + 5) % 16;
                end
                default: begin
                    f = c ^ (b | ~d);
                    g = (7 * t) % 16;
                end
            endcase
            tmp = d;
            d   = c;
            c   = b;
            b   = b + rotate_left(a + f + round_add[t] + block_words[g],
                                  rot_amount[ph * 4 + t % 4]);
            a   = tmp;
        end
        chain_hv[0] = chain_hv[0] + a;
        chain_hv[1] = chain_hv[1] + b;
        chain_hv[2] = chain_hv[2] + c;
        chain_hv[3] = chain_hv[3] + d;
    endtask

    task automatic md5_put_byte(input logic [7:0] value);
        int unsigned sh;
        sh = 8 * block_fill[1:0];
        block_words[block_fill[5:2]][sh +: 8] = value;
        block_fill = block_fill + 6'd1;
        if (block_fill == 6'd0) begin
            md5_compress();
        end
    endtask

    // Takes one message word. On a last word it pads, runs the final block(s),
    // hands back the digest and re-arms for the next message.
    task automatic md5_absorb(input logic [31:0] data, input logic [2:0] cnt,
                              input logic last, output logic done,
                              output logic [127:0] digest);
        int unsigned used;
        logic [63:0] bit_len;
        used = (cnt > 3'd4) ? 4 : cnt;
        for (int i = 0; i < used; i++) begin
            md5_put_byte(data[8 * i +: 8]);
        end
        message_len = message_len + 61'(used);
        done   = 1'b0;
        digest = '0;
        if (last) begin
            bit_len = {message_len, 3'b000};
            md5_put_byte(PAD_BYTE[7:0]);
            while (block_fill != 6'd56) begin
                md5_put_byte(8'h00);
            end
            block_words[14] = bit_len[31:0];
            block_words[15] = bit_len[63:32];
            md5_compress();
            digest = {chain_hv[3], chain_hv[2], chain_hv[1], chain_hv[0]};
            done   = 1'b1;
            md5_restart();
        end
    endtask

    // Presents one request and returns at the edge where it is taken. The
    // sender runs in bursts of random length. Between bursts it drops valid
    // for a random gap, and sometimes it goes straight into the next burst.
    task automatic send_request(input logic [31:0] data, input logic [2:0] cnt,
                                input logic last, input logic typed,
                                input logic [127:0] digest);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_valid          <= 1'b1;
        i_data_word      <= data;
        i_byte_count     <= cnt;
        i_last_word      <= last;
        req_typed        <= typed;
        req_typed_digest <= digest;
        do @(posedge i_clk); while (o_stall);
    endtask

    // The receiver switches between stretches of its own: no stall at all,
    // light stalling, heavy stalling and solid stall.
    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = (stall_mode == 3) ? $urandom_range(1, 30) : $urandom_range(5, 60);
        end
        stall_left--;
        case (stall_mode)
            0:       i_stall <= 1'b0;
            1:       i_stall <= ($urandom_range(0, 3) == 0);
            2:       i_stall <= ($urandom_range(0, 3) != 0);
            default: i_stall <= 1'b1;
        endcase
    end

    // The monitor samples both channels at the clock edge. A digest leaving
    // the engine is checked against the oldest one owed. A request taken by
    // the engine is run through the model, and a last word adds one digest
    // to the queue.
    always @(posedge i_clk) begin : monitor
        logic [127:0] want;
        logic [127:0] model_digest;
        logic         done;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (pending_digests.size() == 0) begin
                    $error("digest with none expected: %h %h %h %h", o_digest_word0,
                           o_digest_word1, o_digest_word2, o_digest_word3);
                    fail_count++;
                end else begin
                    want = pending_digests.pop_front();
                    if (o_digest_word0 !== want[31:0]) begin
                        $error("digest_word0: expected %h, actual %h",
                               want[31:0], o_digest_word0);
                        fail_count++;
                    end
                    if (o_digest_word1 !== want[63:32]) begin
                        $error("digest_word1: expected %h, actual %h",
                               want[63:32], o_digest_word1);
                        fail_count++;
                    end
                    if (o_digest_word2 !== want[95:64]) begin
                        $error("digest_word2: expected %h, actual %h",
                               want[95:64], o_digest_word2);
                        fail_count++;
                    end
                    if (o_digest_word3 !== want[127:96]) begin
                        $error("digest_word3: expected %h, actual %h",
                               want[127:96], o_digest_word3);
                        fail_count++;
                    end
                end
            end
            if (i_valid && !o_stall) begin
                md5_absorb(i_data_word, i_byte_count, i_last_word, done, model_digest);
                if (done) begin
                    pending_digests.push_back(req_typed ? req_typed_digest : model_digest);
                end
            end
        end
    end

    initial begin : stimulus
        int unsigned sent;
        int unsigned n_words;
        int unsigned kind;
        int unsigned waited;
        logic [2:0]  cnt;
        md5_restart();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < DIRECTED_ROWS; r++) begin
            send_request(directed_rows[r].data, directed_rows[r].cnt, directed_rows[r].last,
                         directed_rows[r].typed, directed_rows[r].digest);
        end

        // Random messages. Most are short. Many have 52 to 72 bytes, which
        // lands on the boundary where the length field forces an extra block.
        // A few run to several blocks. About one word in eight inside a
        // message carries an odd count, and the last word takes any count.
        sent = 0;
        while (sent < RANDOM_REQUESTS) begin
            kind = $urandom_range(0, 9);
            if (kind < 6) begin
                n_words = $urandom_range(0, 12);
            end else if (kind < 9) begin
                n_words = $urandom_range(13, 17);
            end else begin
                n_words = $urandom_range(18, 40);
            end
            for (int w = 0; w < n_words; w++) begin
                cnt = ($urandom_range(0, 7) == 0) ? 3'($urandom_range(0, 7)) : 3'd4;
                send_request($urandom, cnt, 1'b0, 1'b0, '0);
                sent++;
            end
            send_request($urandom, 3'($urandom_range(0, 7)), 1'b1, 1'b0, '0);
            sent++;
        end
        i_valid <= 1'b0;

        // Let the last digests drain, then give the engine time to show any
        // digest that it should not produce.
        waited = 0;
        while (pending_digests.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (pending_digests.size() != 0) begin
            $error("%0d digest(s) never arrived", pending_digests.size());
            fail_count++;
        end

        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // Backstop in case the engine hangs.
    initial begin
        #10_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

[files.f]
rtl/core/md5_pkg.sv
rtl/core/md5_round.sv
rtl/core/md5_hash_engine.sv
bench/md5_hash_engine_tb.sv
